/* hw/rtl/linear_hash_table_unit_assert.svh */
// Assertion macros for the linear hash table unit
`ifndef LINEAR_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_HASH_TABLE_UNIT_ASSERT_SVH
// implication checked on every clock, off during reset
`define LHT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked on every clock, off during reset
`define LHT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/lht_pkg.sv */
// Package with sizes, status codes and helpers for the linear hash table
`timescale 1ns / 1ps
package lht_pkg;
    localparam int MAX_BUCKETS      = 64;
    localparam int PAGES_PER_BUCKET = 4;
    localparam int MAX_PAGE_SLOTS   = 8;
    localparam int SLOTS            = PAGES_PER_BUCKET * MAX_PAGE_SLOTS;
    localparam int BKT_W            = $clog2(MAX_BUCKETS);
    localparam int SLOT_W           = $clog2(SLOTS);
    localparam int FILL_W           = $clog2(SLOTS + 1);
    localparam int TOT_W            = $clog2(MAX_BUCKETS + 1);
    localparam int ADDR_W           = BKT_W + SLOT_W;
    localparam int ENT_W            = $clog2(MAX_BUCKETS * SLOTS + 1);
    localparam int LVL_W            = 3;
    localparam int KEY_W            = 31;
    localparam int ZIP_W            = 17;
    localparam int STAT_W           = 3;
    localparam int KPP_W            = 4;
    localparam int LOAD_W           = ENT_W + 4;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ZIP_W-1:0] zip;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // n never exceeds 15, so the mask always keeps fewer than KEY_W bits
    function automatic logic [KEY_W-1:0] low_bits(input logic [KEY_W-1:0] k,
                                                  input logic [LVL_W:0] n);
        logic [KEY_W-1:0] m;
        m = (KEY_W'(1) << n) - KEY_W'(1);
        return k & m;
    endfunction
endpackage

/* hw/rtl/lht_store.sv */
// Entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module lht_store (
    input  logic              aclk,
    input  lht_pkg::mem_req_t req,
    output lht_pkg::entry_t   rdata
);
    import lht_pkg::*;
    entry_t mem [MAX_BUCKETS*SLOTS];
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule

/* hw/rtl/linear_hash_table_unit.sv */
// Top level of the linear hash table unit
// channel | dir | tdata fields (low bit up)          | tuser
// s_axis  | in  | key[30:0], zip_in[47:31]           | mode
// m_axis  | out | status[2:0], zip_out[19:3]         | -
// From accept to result: fill read, one slot read per cycle on the single read
// port of the entry memory, decide; when a split runs, the fill of the split
// bucket is read and its slots are scanned and moved the same way. Fill counts
// sit in a memory with registered read; a valid flop per bucket makes an
// unwritten count read as zero, so no clearing pass. Reset is synchronous,
// active low. A result waits in the zout_reg and stat_reg holding registers;
// the next item is taken only once that result has left.
`timescale 1ns / 1ps
module linear_hash_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key, zip_in
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status, zip_out, zero pad
);
    import lht_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DONE  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;
    localparam logic [2:0] S_SLOAD = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [KPP_W-1:0]  kpp_reg;
    logic [FILL_W-1:0] fill_mem [MAX_BUCKETS];
    logic              fvld_reg [MAX_BUCKETS];
    logic [FILL_W-1:0] fill_rd_reg;
    logic              fvld_rd_reg;
    logic              fill_we;
    logic [BKT_W-1:0]  fill_waddr, fill_raddr;
    logic [FILL_W-1:0] fill_wdata, fill_rd;
    logic [LVL_W-1:0]  level_reg;
    logic [BKT_W-1:0]  sp_reg;
    logic [TOT_W-1:0]  btot_reg, rstart_reg;
    logic [ENT_W-1:0]  etot_reg;
    logic              mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [ZIP_W-1:0]  zip_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [FILL_W-1:0] n_reg, i_reg, keep_reg, dcnt_reg;
    logic              rv_reg, hit_reg;
    logic [ZIP_W-1:0]  zout_reg;
    logic [STAT_W-1:0] stat_reg;
    mem_req_t          req;
    entry_t            rdata;

    lht_store u_store (.aclk(aclk), .req(req), .rdata(rdata));

    logic [KPP_W-1:0]  kpp;
    logic [FILL_W-1:0] cap;
    logic [KEY_W-1:0]  a1, a2, in_key;
    logic [BKT_W-1:0]  addr;
    logic [LOAD_W-1:0] lhs, rhs;
    logic [BKT_W-1:0]  dst;
    logic              moves;

    assign kpp    = (kpp_reg > KPP_W'(MAX_PAGE_SLOTS)) ? KPP_W'(MAX_PAGE_SLOTS) : kpp_reg;
    assign cap    = FILL_W'(PAGES_PER_BUCKET * 1) * FILL_W'(kpp);
    assign in_key = s_axis_tdata[KEY_W-1:0];
    assign a1     = low_bits(in_key, {1'b0, level_reg} + (LVL_W+1)'(1));
    assign a2     = low_bits(in_key, {1'b0, level_reg} + (LVL_W+1)'(2));
    assign addr   = (a1 < KEY_W'(sp_reg)) ? a2[BKT_W-1:0] : a1[BKT_W-1:0];
    assign lhs    = LOAD_W'(etot_reg) << 2;
    assign rhs    = LOAD_W'(3) * LOAD_W'(btot_reg) * LOAD_W'(kpp);
    assign dst    = btot_reg[BKT_W-1:0];
    assign moves  = low_bits(rdata.key, {1'b0, level_reg} + (LVL_W+1)'(2)) == KEY_W'(btot_reg);

    assign fill_raddr = (state_reg == S_DONE) ? sp_reg : addr;
    assign fill_rd    = fvld_rd_reg ? fill_rd_reg : '0;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {4'd0, zout_reg, stat_reg};

    always_ff @(posedge aclk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        fill_rd_reg <= fill_mem[fill_raddr];
    end

    always_comb begin
        req = '0;
        fill_we = 1'b0;
        fill_waddr = bkt_reg;
        fill_wdata = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) state_next = S_LOAD;
            end
            S_LOAD: begin
                state_next = S_SCAN;
            end
            S_SCAN: begin
                req.raddr = {bkt_reg, i_reg[SLOT_W-1:0]};
                if (rv_reg && rdata.key == key_reg) state_next = S_DONE;
                else if (i_reg >= n_reg && !rv_reg) state_next = S_DONE;
            end
            S_DONE: begin
                req.we    = !mode_reg && !hit_reg && (n_reg < cap);
                req.waddr = {bkt_reg, n_reg[SLOT_W-1:0]};
                req.wdata = '{key: key_reg, zip: zip_reg};
                req.raddr = {sp_reg, SLOT_W'(0)};
                fill_we    = req.we;
                fill_waddr = bkt_reg;
                fill_wdata = n_reg + FILL_W'(1);
                state_next = S_OUT;
                if (req.we && (lhs + LOAD_W'(4) >= rhs) && btot_reg < TOT_W'(MAX_BUCKETS))
                    state_next = S_SLOAD;
            end
            S_SLOAD: begin
                state_next = S_SPLIT;
            end
            S_SPLIT: begin
                req.raddr = {sp_reg, i_reg[SLOT_W-1:0]};
                if (rv_reg) begin
                    req.we    = 1'b1;
                    req.wdata = rdata;
                    req.waddr = moves ? {dst, dcnt_reg[SLOT_W-1:0]}
                                      : {sp_reg, keep_reg[SLOT_W-1:0]};
                    if (moves) begin
                        fill_we    = 1'b1;
                        fill_waddr = dst;
                        fill_wdata = dcnt_reg + FILL_W'(1);
                    end
                end
                if (i_reg >= n_reg && !rv_reg) begin
                    fill_we    = 1'b1;
                    fill_waddr = sp_reg;
                    fill_wdata = keep_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            kpp_reg    <= KPP_W'(4);
            level_reg  <= '0;
            sp_reg     <= '0;
            btot_reg   <= TOT_W'(2);
            rstart_reg <= TOT_W'(2);
            etot_reg   <= '0;
            rv_reg     <= 1'b0;
            for (int b = 0; b < MAX_BUCKETS; b++) fvld_reg[b] <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) kpp_reg <= cfg_wdata;
            if (fill_we) fvld_reg[fill_waddr] <= 1'b1;
            fvld_rd_reg <= fvld_reg[fill_raddr];
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        mode_reg <= s_axis_tuser;
                        key_reg  <= in_key;
                        zip_reg  <= s_axis_tdata[KEY_W+ZIP_W-1:KEY_W];
                        bkt_reg  <= addr;
                        i_reg    <= '0;
                        rv_reg   <= 1'b0;
                        hit_reg  <= 1'b0;
                        zout_reg <= '0;
                    end
                end
                S_LOAD: begin
                    n_reg <= fill_rd;
                end
                S_SCAN: begin
                    rv_reg <= (i_reg < n_reg);
                    i_reg  <= i_reg + FILL_W'(1);
                    if (rv_reg && rdata.key == key_reg) begin
                        hit_reg  <= 1'b1;
                        zout_reg <= rdata.zip;
                    end
                end
                S_DONE: begin
                    rv_reg <= 1'b0;
                    if (mode_reg) begin
                        stat_reg <= hit_reg ? ST_FOUND : ST_NOT_FOUND;
                    end else begin
                        zout_reg <= '0;
                        if (hit_reg) stat_reg <= ST_DUPLICATE;
                        else if (n_reg >= cap) stat_reg <= ST_FULL;
                        else begin
                            stat_reg <= ST_INSERTED;
                            etot_reg <= etot_reg + ENT_W'(1);
                        end
                    end
                    i_reg    <= '0;
                    keep_reg <= '0;
                    dcnt_reg <= '0;
                end
                S_SLOAD: begin
                    n_reg <= (sp_reg == bkt_reg) ? n_reg + FILL_W'(1) : fill_rd;
                end
                S_SPLIT: begin
                    rv_reg <= (i_reg < n_reg);
                    i_reg  <= i_reg + FILL_W'(1);
                    if (rv_reg) begin
                        if (moves) dcnt_reg <= dcnt_reg + FILL_W'(1);
                        else keep_reg <= keep_reg + FILL_W'(1);
                    end
                    if (i_reg >= n_reg && !rv_reg) begin
                        btot_reg <= btot_reg + TOT_W'(1);
                        if (btot_reg + TOT_W'(1) == (rstart_reg << 1)) begin
                            sp_reg     <= '0;
                            level_reg  <= level_reg + LVL_W'(1);
                            rstart_reg <= btot_reg + TOT_W'(1);
                        end else begin
                            sp_reg <= sp_reg + BKT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

/* hw/rtl/lht_checker.sv */
// Port checker for the linear hash table unit, bound to the top level
`timescale 1ns / 1ps
`include "linear_hash_table_unit_assert.svh"
module lht_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    `LHT_ASSERT_IMP(a_excl, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "ready while result waits")
    `LHT_ASSERT_NXT(a_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
    `LHT_ASSERT_IMP(a_code, aclk, aresetn, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd4, "bad status")
    `LHT_ASSERT_NXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

bind linear_hash_table_unit lht_checker u_lht_checker (.*);
